@@ src/flpv_pkg.sv @@
// ---------------------------------------------------------------------------
// flpv_pkg: shared types, constants and helpers for the packet validator
// Holds the packet length, the verdict codes and the character class
// and hex digit helpers used by the check stage.
// ---------------------------------------------------------------------------
package flpv_pkg;

	// Packet geometry. The position counter is 8 bits wide, so the length
	// may range from 10 to 255.
	localparam int PACKET_LENGTH = 20;
	localparam int PosW          = 8;

	localparam logic [PosW-1:0] PktLen      = PosW'(PACKET_LENGTH);
	localparam logic [PosW-1:0] LastPos     = PosW'(PACKET_LENGTH - 1);
	localparam logic [PosW-1:0] LowDigPos   = PosW'(PACKET_LENGTH - 2);
	localparam logic [PosW-1:0] HighDigPos  = PosW'(PACKET_LENGTH - 3);
	localparam logic [PosW-1:0] SumEndPos   = PosW'(PACKET_LENGTH - 4);
	localparam logic [PosW-1:0] AdjPos      = PosW'(4);
	localparam logic [PosW-1:0] SumStartPos = PosW'(5);

	localparam logic [7:0] CharZero = 8'h30;

	// Verdict codes, first failing check wins.
	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_BAD_START = 3'd1,
		VERDICT_BAD_END   = 3'd2,
		VERDICT_BAD_DATA  = 3'd3,
		VERDICT_BAD_SUM   = 3'd4
	} verdict_t;

	// True for '0'-'9', 'A'-'Z' and 'a'-'z'.
	function automatic logic is_alnum(input logic [7:0] b);
		return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	// Uppercase ASCII hex digit for the low nibble of the argument.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h41 + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

@@ src/fixed_length_packet_validator_top.sv @@
// ---------------------------------------------------------------------------
// fixed_length_packet_validator_top: fixed-length ASCII packet checker
// Checks start byte, end byte, alphanumeric body and a two-digit hex
// checksum, and emits one verdict item on the last byte of each packet.
// ---------------------------------------------------------------------------
//
//   channel   direction  tdata                      tuser
//   s_axis    in         [7:0] data_byte            packet_start
//   m_axis    out        [2:0] verdict, [7:3] zero  -
//
// One byte is taken per cycle while the check stage is not held. A byte
// passes an input register, is checked there against the packet state,
// and its verdict is then stored in the result register.
// Reset clears the packet state and both valid flags.
// An unread verdict in the result register holds the check stage only when
// the byte there is the last of a packet, which in turn holds off new bytes
// once the input register is full.
// ---------------------------------------------------------------------------
module fixed_length_packet_validator_top
	import flpv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] packet_start
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [2:0] verdict, [7:3] zero
);

	// Input register stage.
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Packet state.
	logic [PosW-1:0] pos_q;
	logic [7:0]      sum_q;
	logic            start_fail_q;
	logic            data_fail_q;
	logic            adjust_q;
	logic [7:0]      high_dig_q;
	logic [7:0]      low_dig_q;

	// Result register.
	logic     out_vld_q;
	verdict_t verdict_q;

	// Effective state after a possible restart, and next state.
	logic [PosW-1:0] pos_e;
	logic [7:0]      sum_e;
	logic            start_fail_e;
	logic            data_fail_e;
	logic            adjust_e;
	logic [7:0]      high_dig_e;
	logic [7:0]      low_dig_e;
	logic [PosW-1:0] pos_d;
	logic [7:0]      sum_d;
	logic            start_fail_d;
	logic            data_fail_d;
	logic            adjust_d;
	logic [7:0]      high_dig_d;
	logic [7:0]      low_dig_d;
	logic            in_pkt;
	logic            is_last;
	logic [7:0]      chk;
	verdict_t        verdict_d;

	logic out_free;
	logic adv_s1;

	// Handshake: a byte that produces a verdict moves only when the result
	// slot is free; any other byte moves right away.
	assign out_free      = !out_vld_q || m_axis_tready;
	assign adv_s1        = vld_s1 && (out_free || !is_last);
	assign s_axis_tready = !vld_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Per-byte checks and state update.
	always_comb begin
		pos_e        = start_s1 ? '0 : pos_q;
		sum_e        = start_s1 ? '0 : sum_q;
		start_fail_e = start_s1 ? 1'b0 : start_fail_q;
		data_fail_e  = start_s1 ? 1'b0 : data_fail_q;
		adjust_e     = start_s1 ? 1'b0 : adjust_q;
		high_dig_e   = start_s1 ? '0 : high_dig_q;
		low_dig_e    = start_s1 ? '0 : low_dig_q;

		in_pkt  = pos_e < PktLen;
		is_last = in_pkt && (pos_e == LastPos);

		pos_d        = pos_e;
		sum_d        = sum_e;
		start_fail_d = start_fail_e;
		data_fail_d  = data_fail_e;
		adjust_d     = adjust_e;
		high_dig_d   = high_dig_e;
		low_dig_d    = low_dig_e;

		if (in_pkt) begin
			pos_d = pos_e + PosW'(1);
			if (pos_e == '0) begin
				if (byte_s1 == 8'h00 || is_alnum(byte_s1)) begin
					start_fail_d = 1'b1;
				end
			end else if (pos_e <= HighDigPos) begin
				if (!is_alnum(byte_s1)) begin
					data_fail_d = 1'b1;
				end
			end
			if (pos_e == AdjPos && byte_s1 == CharZero) begin
				adjust_d = 1'b1;
			end
			if (pos_e >= SumStartPos && pos_e <= SumEndPos) begin
				sum_d = sum_e + byte_s1;
			end
			if (pos_e == HighDigPos) begin
				high_dig_d = byte_s1;
			end
			if (pos_e == LowDigPos) begin
				low_dig_d = byte_s1;
			end
		end

		// Verdict on the last byte, first failure in check order.
		chk = sum_e - 8'd1 - {7'd0, adjust_e};
		if (start_fail_e) begin
			verdict_d = VERDICT_BAD_START;
		end else if (is_alnum(byte_s1)) begin
			verdict_d = VERDICT_BAD_END;
		end else if (data_fail_e) begin
			verdict_d = VERDICT_BAD_DATA;
		end else if (hex_char(chk[3:0]) != low_dig_e
				|| hex_char(chk[7:4]) != high_dig_e) begin
			verdict_d = VERDICT_BAD_SUM;
		end else begin
			verdict_d = VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			start_fail_q <= 1'b0;
			data_fail_q  <= 1'b0;
			adjust_q     <= 1'b0;
			high_dig_q   <= '0;
			low_dig_q    <= '0;
		end else if (adv_s1) begin
			pos_q        <= pos_d;
			sum_q        <= sum_d;
			start_fail_q <= start_fail_d;
			data_fail_q  <= data_fail_d;
			adjust_q     <= adjust_d;
			high_dig_q   <= high_dig_d;
			low_dig_q    <= low_dig_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv_s1 && is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_last) begin
			verdict_q <= verdict_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, verdict_q};

endmodule

@@ tb/packet_verdict_checker.sv @@
// ---------------------------------------------------------------------------
// packet_verdict_checker: scoreboard for the fixed-length packet validator
// Watches the byte stream going in, tracks the packet state on its own,
// queues one expected verdict per completed packet and compares each
// verdict item leaving the block against the oldest one queued.
// ---------------------------------------------------------------------------
module packet_verdict_checker
	import flpv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_data,    // [7:0] data_byte
	input  logic       in_start,   // [0] packet_start
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_data,   // [2:0] verdict, [7:3] zero
	output int         fail_count,
	output int         pending_count
);

	// Packet state as the block should see it.
	logic [7:0] pkt_pos;
	logic [7:0] chk_sum;
	logic [7:0] hi_seen;
	logic [7:0] lo_seen;
	bit         start_bad;
	bit         body_bad;
	bit         zero_adjust;

	verdict_t   verdict_queue[$];
	verdict_t   predicted;
	verdict_t   wanted;
	bit         emits;

	function automatic bit alnum_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// Uppercase hex digit of a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
	endfunction

	task automatic report_mismatch(input string what);
		$display("checker: %s at %0t", what, $time);
		fail_count++;
	endtask

	task automatic clear_packet_state();
		pkt_pos     = 8'd0;
		chk_sum     = 8'd0;
		hi_seen     = 8'd0;
		lo_seen     = 8'd0;
		start_bad   = 1'b0;
		body_bad    = 1'b0;
		zero_adjust = 1'b0;
	endtask

	// Advance the packet state by one byte; a verdict falls out on the last one.
	task automatic predict_byte(input logic [7:0] b, input logic st, output bit done,
		output verdict_t v);
		logic [7:0] sum;
		done = 1'b0;
		v    = VERDICT_OK;
		if (st) begin
			clear_packet_state();
		end
		// Bytes past the end of a packet are dropped until the next start mark.
		if (pkt_pos < PktLen) begin
			if (pkt_pos == 8'd0) begin
				if (b == 8'd0 || alnum_char(b)) begin
					start_bad = 1'b1;
				end
			end else if (pkt_pos <= HighDigPos) begin
				if (!alnum_char(b)) begin
					body_bad = 1'b1;
				end
			end
			if (pkt_pos == AdjPos && b == CharZero) begin
				zero_adjust = 1'b1;
			end
			if (pkt_pos >= SumStartPos && pkt_pos <= SumEndPos) begin
				chk_sum = chk_sum + b;
			end
			if (pkt_pos == HighDigPos) begin
				hi_seen = b;
			end
			if (pkt_pos == LowDigPos) begin
				lo_seen = b;
			end
			if (pkt_pos == LastPos) begin
				sum  = chk_sum - 8'd1 - {7'd0, zero_adjust};
				done = 1'b1;
				if (start_bad) begin
					v = VERDICT_BAD_START;
				end else if (alnum_char(b)) begin
					v = VERDICT_BAD_END;
				end else if (body_bad) begin
					v = VERDICT_BAD_DATA;
				end else if (hex_digit(sum[7:4]) != hi_seen || hex_digit(sum[3:0]) != lo_seen) begin
					v = VERDICT_BAD_SUM;
				end
			end
			pkt_pos = pkt_pos + 8'd1;
		end
	endtask

	// Predict on accepted bytes and compare on accepted verdicts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet_state();
			verdict_queue.delete();
			fail_count    = 0;
			pending_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(in_data, in_start, emits, predicted);
				if (emits) begin
					verdict_queue.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				if (verdict_queue.size() == 0) begin
					report_mismatch($sformatf("verdict %0d with none expected", out_data[2:0]));
				end else begin
					wanted = verdict_queue.pop_front();
					if (out_data[2:0] != wanted) begin
						report_mismatch($sformatf("verdict %0d, expected %0d",
							out_data[2:0], wanted));
					end
					if (out_data[7:3] != 5'd0) begin
						report_mismatch($sformatf("padding bits 0x%0h not zero", out_data[7:3]));
					end
				end
			end
			pending_count = verdict_queue.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for the fixed-length packet validator
// Builds packets with chosen defects, streams them in bursts while the
// verdict side stalls on its own pattern, and lets the checker judge.
// ---------------------------------------------------------------------------
module tb_top;
	import flpv_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_START_ZERO,
		FLAW_START_ALNUM,
		FLAW_END,
		FLAW_BODY,
		FLAW_HIGH_DIGIT,
		FLAW_LOW_DIGIT,
		FLAW_SEVERAL
	} flaw_e;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_e;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;   // [7:0] data_byte
	logic       s_axis_tuser  = 1'b0;   // [0] packet_start
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [2:0] verdict, [7:3] zero

	int         check_failures;
	int         verdicts_pending;

	logic [7:0] pkt_bytes [PACKET_LENGTH];
	string      hex_chars   = "0123456789ABCDEF";
	string      alnum_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	int         burst_left  = 0;
	int         packet_items = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fixed_length_packet_validator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	packet_verdict_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_data       (s_axis_tdata),
		.in_start      (s_axis_tuser),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata),
		.fail_count    (check_failures),
		.pending_count (verdicts_pending)
	);

	function automatic logic [7:0] rand_alnum();
		return alnum_chars[$urandom_range(0, 61)];
	endfunction

	// Any non-zero byte outside the letter and digit ranges.
	function automatic logic [7:0] rand_symbol();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'($urandom_range(8'h01, 8'h2F));
			1: c = 8'($urandom_range(8'h3A, 8'h40));
			2: c = 8'($urandom_range(8'h5B, 8'h60));
			default: c = 8'($urandom_range(8'h7B, 8'hFF));
		endcase
		return c;
	endfunction

	// Fill pkt_bytes with a well-formed packet, then plant the requested defect.
	task automatic build_packet(input flaw_e flaw, input bit adj_zero);
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		pkt_bytes[0] = rand_symbol();
		for (int i = 1; i <= PACKET_LENGTH - 4; i++) begin
			pkt_bytes[i] = rand_alnum();
		end
		if (adj_zero) begin
			pkt_bytes[4] = CharZero;
		end
		sum = 8'd0;
		for (int i = 5; i <= PACKET_LENGTH - 4; i++) begin
			sum = sum + pkt_bytes[i];
		end
		sum = sum - 8'd1 - ((pkt_bytes[4] == CharZero) ? 8'd1 : 8'd0);
		hi  = hex_chars[sum[7:4]];
		lo  = hex_chars[sum[3:0]];
		pkt_bytes[PACKET_LENGTH - 3] = hi;
		pkt_bytes[PACKET_LENGTH - 2] = lo;
		pkt_bytes[PACKET_LENGTH - 1] = ($urandom_range(0, 7) == 0) ? 8'h00 : rand_symbol();
		case (flaw)
			FLAW_START_ZERO: begin
				pkt_bytes[0] = 8'h00;
			end
			FLAW_START_ALNUM: begin
				pkt_bytes[0] = rand_alnum();
			end
			FLAW_END: begin
				pkt_bytes[PACKET_LENGTH - 1] = rand_alnum();
			end
			FLAW_BODY: begin
				pkt_bytes[$urandom_range(1, PACKET_LENGTH - 3)] = rand_symbol();
			end
			FLAW_HIGH_DIGIT: begin
				do pkt_bytes[PACKET_LENGTH - 3] = rand_alnum();
				while (pkt_bytes[PACKET_LENGTH - 3] == hi);
			end
			FLAW_LOW_DIGIT: begin
				do pkt_bytes[PACKET_LENGTH - 2] = 8'($urandom_range(0, 255));
				while (pkt_bytes[PACKET_LENGTH - 2] == lo);
			end
			FLAW_SEVERAL: begin
				pkt_bytes[0] = 8'h00;
				pkt_bytes[PACKET_LENGTH - 1] = rand_alnum();
				pkt_bytes[$urandom_range(1, PACKET_LENGTH - 3)] = rand_symbol();
			end
			default: begin
			end
		endcase
	endtask

	// Offer one item; the sender pauses between bursts of random length.
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	// Send the first count bytes of pkt_bytes, marking byte 0 if asked.
	task automatic send_packet(input bit mark, input int count);
		for (int i = 0; i < count; i++) begin
			send_byte(pkt_bytes[i], mark && i == 0);
		end
		packet_items += count;
	endtask

	// Stimulus and verdict.
	initial begin
		int roll;
		flaw_e flaw;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset the first byte counts as byte 0 without a mark.
		build_packet(FLAW_NONE, 1'b1);
		send_packet(1'b0, PACKET_LENGTH);
		// Bytes after the end of a packet are ignored.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b0);
		// One packet for each kind of defect.
		for (int f = FLAW_NONE; f <= FLAW_SEVERAL; f++) begin
			build_packet(flaw_e'(f), f == FLAW_NONE);
			send_packet(1'b1, PACKET_LENGTH);
		end
		// A start mark in mid-packet drops the partial packet.
		build_packet(FLAW_NONE, 1'b0);
		send_packet(1'b1, 7);
		build_packet(FLAW_NONE, 1'b0);
		send_packet(1'b1, PACKET_LENGTH);

		// Random packets, about half well formed, some cut short or trailed by noise.
		packet_items = 0;
		while (packet_items < 600) begin
			flaw = ($urandom_range(0, 9) < 5) ? FLAW_NONE
				: flaw_e'($urandom_range(FLAW_START_ZERO, FLAW_SEVERAL));
			build_packet(flaw, $urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_packet(1'b1, $urandom_range(1, PACKET_LENGTH - 1));
			end else begin
				send_packet(1'b1, PACKET_LENGTH);
				if (roll < 16) begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		// Drain the verdicts still due, then allow the pipeline to settle.
		while (verdicts_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (check_failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Verdict side: stall pattern in phases, with one long hold-off mid-run.
	initial begin
		rx_mode_e mode;
		int span;
		int cycles;
		bit held;
		cycles = 0;
		held   = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && cycles >= 300) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				held = 1'b1;
			end
			mode = rx_mode_e'($urandom_range(RX_OPEN, RX_SPARSE));
			span = $urandom_range(10, 60);
			repeat (span) begin
				case (mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
					default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
				cycles++;
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
